// ----- rtl/wffgc_pkg.sv -----
// package for the weighted first-fit graph coloring unit
// holds sizes, register indexes, controller codes and the saturating adder
`timescale 1ns / 1ps
package wffgc_pkg;

  localparam int MAX_NODES     = 32;
  localparam int WEIGHT_BITS   = 48;
  localparam int NODE_BITS     = $clog2(MAX_NODES);
  localparam int CNT_BITS      = NODE_BITS + 1;
  localparam int ADDR_BITS     = 2 * NODE_BITS;
  localparam int CELLS         = MAX_NODES * MAX_NODES;
  localparam int POS_BITS      = ADDR_BITS + 1;
  localparam int EDGE_BITS     = 8;
  localparam int COLOR_BITS    = 5;
  localparam int USED_BITS     = 6;
  localparam int PASS_BITS     = 4;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CNT_BITS-1:0]  NODE_COUNT_RESET = CNT_BITS'(MAX_NODES);
  localparam logic [PASS_BITS-1:0] PASSES_RESET     = PASS_BITS'(1);

  localparam logic REG_NODE_COUNT    = 1'b0;
  localparam logic REG_WEIGHT_PASSES = 1'b1;

  typedef logic [WEIGHT_BITS-1:0] weight_t;

  typedef enum logic [3:0] {
    OP_LOAD, OP_RS_RD, OP_RS_ACC, OP_EU_VRD, OP_EU_VCAP, OP_EU_RD, OP_EU_WR,
    OP_PK_RD, OP_PK_CMP, OP_CO_RD, OP_CO_ACC, OP_CO_SET, OP_DB_RD, OP_DB_WR,
    OP_OUT_RD, OP_OUT_SHOW
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RS_RD, ST_RS_ACC, ST_EU_VRD, ST_EU_VCAP, ST_EU_RD, ST_EU_WR,
    ST_RW_RD, ST_RW_ACC, ST_PK_RD, ST_PK_CMP, ST_CO_RD, ST_CO_ACC, ST_CO_SET,
    ST_DB_RD, ST_DB_WR, ST_OUT_RD, ST_OUT_SHOW
  } state_t;

  typedef struct packed {
    op_t  op;
    logic to_weight;
  } cmd_t;

  typedef struct packed {
    logic go;
    logic j_last;
    logic i_last;
    logic pass_last;
    logic k_last;
    logic out_free;
  } status_t;

  function automatic weight_t sat_add(weight_t a, weight_t b);
    logic [WEIGHT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WEIGHT_BITS] ? {WEIGHT_BITS{1'b1}} : s[WEIGHT_BITS-1:0];
  endfunction

endpackage

// ----- rtl/wffgc_in_if.sv -----
// matrix entry channel: valid, ready and one adjacency entry
// uses wffgc_pkg for field widths
`timescale 1ns / 1ps
interface wffgc_in_if;
  logic                            valid;
  logic                            ready;
  logic [wffgc_pkg::EDGE_BITS-1:0] edge_weight;
  logic                            matrix_last;
  modport source(output valid, edge_weight, matrix_last, input ready);
  modport sink(input valid, edge_weight, matrix_last, output ready);
endinterface

// ----- rtl/wffgc_out_if.sv -----
// result channel: valid, ready and one node color report
// uses wffgc_pkg for field widths
`timescale 1ns / 1ps
interface wffgc_out_if;
  logic                             valid;
  logic                             ready;
  logic [wffgc_pkg::NODE_BITS-1:0]  node_index;
  logic [wffgc_pkg::COLOR_BITS-1:0] node_color;
  logic [wffgc_pkg::USED_BITS-1:0]  colors_used;
  logic                             result_last;
  modport source(output valid, node_index, node_color, colors_used, result_last, input ready);
  modport sink(input valid, node_index, node_color, colors_used, result_last, output ready);
endinterface

// ----- rtl/weighted_first_fit_graph_coloring_unit.sv -----
// Weighted first-fit graph coloring unit: takes one adjacency entry per beat in row-major order
// while idle. After the beat with matrix_last it runs the weighting passes and greedy coloring,
// then returns one result beat per node. Every matrix entry goes through the edge memory in a read
// state and then a use state, in each weighting pass and in coloring. No clearing pass.
// uses wffgc_pkg, wffgc_in_if, wffgc_out_if, wffgc_cfg, wffgc_ctrl, wffgc_dp
`timescale 1ns / 1ps
module weighted_first_fit_graph_coloring_unit (
  input  logic                                clk,
  input  logic                                rst,
  wffgc_in_if.sink                            matrix,
  wffgc_out_if.source                         result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wffgc_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [wffgc_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [wffgc_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                pready
);
  logic [wffgc_pkg::CNT_BITS-1:0]  node_count;
  logic [wffgc_pkg::PASS_BITS-1:0] weight_passes;
  wffgc_pkg::cmd_t    cmd;
  wffgc_pkg::status_t status;

  wffgc_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .node_count(node_count), .weight_passes(weight_passes)
  );

  wffgc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .status(status), .cmd(cmd)
  );

  wffgc_dp u_dp (
    .clk(clk), .rst(rst), .node_count(node_count), .weight_passes(weight_passes),
    .cmd(cmd), .status(status), .matrix(matrix), .result(result)
  );

  a_color_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.colors_used > wffgc_pkg::USED_BITS'(result.node_color)))
    else $error("node color not below colors used");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && result.result_last) |=> !result.valid)
    else $error("result beat right after final node");
endmodule

// ----- rtl/wffgc_cfg.sv -----
// apb register file: node_count and weight_passes
// uses wffgc_pkg
`timescale 1ns / 1ps
module wffgc_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wffgc_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [wffgc_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [wffgc_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                 pready,
  output logic [wffgc_pkg::CNT_BITS-1:0]       node_count,
  output logic [wffgc_pkg::PASS_BITS-1:0]      weight_passes
);
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count    <= wffgc_pkg::NODE_COUNT_RESET;
      weight_passes <= wffgc_pkg::PASSES_RESET;
    end else if (wr) begin
      if (paddr[2] == wffgc_pkg::REG_NODE_COUNT) begin
        node_count <= pwdata[wffgc_pkg::CNT_BITS-1:0];
      end else begin
        weight_passes <= pwdata[wffgc_pkg::PASS_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == wffgc_pkg::REG_WEIGHT_PASSES) begin
      prdata = wffgc_pkg::CFG_DATA_BITS'(weight_passes);
    end else begin
      prdata = wffgc_pkg::CFG_DATA_BITS'(node_count);
    end
  end
endmodule

// ----- rtl/wffgc_ctrl.sv -----
// sequencer for load, weighting passes, greedy coloring and result output
// uses wffgc_pkg state, command and status types
`timescale 1ns / 1ps
module wffgc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  wffgc_pkg::status_t status,
  output wffgc_pkg::cmd_t    cmd
);
  wffgc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wffgc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wffgc_pkg::ST_IDLE:    if (status.go) state_next = wffgc_pkg::ST_RS_RD;
      wffgc_pkg::ST_RS_RD:   state_next = wffgc_pkg::ST_RS_ACC;
      wffgc_pkg::ST_RS_ACC: begin
        if (status.j_last && status.i_last) state_next = wffgc_pkg::ST_EU_VRD;
        else state_next = wffgc_pkg::ST_RS_RD;
      end
      wffgc_pkg::ST_EU_VRD:  state_next = wffgc_pkg::ST_EU_VCAP;
      wffgc_pkg::ST_EU_VCAP: state_next = wffgc_pkg::ST_EU_RD;
      wffgc_pkg::ST_EU_RD:   state_next = wffgc_pkg::ST_EU_WR;
      wffgc_pkg::ST_EU_WR: begin
        if (!status.j_last) state_next = wffgc_pkg::ST_EU_RD;
        else if (status.i_last) state_next = wffgc_pkg::ST_RW_RD;
        else state_next = wffgc_pkg::ST_EU_VRD;
      end
      wffgc_pkg::ST_RW_RD:   state_next = wffgc_pkg::ST_RW_ACC;
      wffgc_pkg::ST_RW_ACC: begin
        if (!(status.j_last && status.i_last)) state_next = wffgc_pkg::ST_RW_RD;
        else if (status.pass_last) state_next = wffgc_pkg::ST_PK_RD;
        else state_next = wffgc_pkg::ST_RS_RD;
      end
      wffgc_pkg::ST_PK_RD:   state_next = wffgc_pkg::ST_PK_CMP;
      wffgc_pkg::ST_PK_CMP: begin
        if (status.i_last) state_next = wffgc_pkg::ST_CO_RD;
        else state_next = wffgc_pkg::ST_PK_RD;
      end
      wffgc_pkg::ST_CO_RD:   state_next = wffgc_pkg::ST_CO_ACC;
      wffgc_pkg::ST_CO_ACC: begin
        if (status.j_last) state_next = wffgc_pkg::ST_CO_SET;
        else state_next = wffgc_pkg::ST_CO_RD;
      end
      wffgc_pkg::ST_CO_SET:  state_next = wffgc_pkg::ST_DB_RD;
      wffgc_pkg::ST_DB_RD:   state_next = wffgc_pkg::ST_DB_WR;
      wffgc_pkg::ST_DB_WR: begin
        if (!status.j_last) state_next = wffgc_pkg::ST_DB_RD;
        else if (status.k_last) state_next = wffgc_pkg::ST_OUT_RD;
        else state_next = wffgc_pkg::ST_PK_RD;
      end
      wffgc_pkg::ST_OUT_RD:  state_next = wffgc_pkg::ST_OUT_SHOW;
      wffgc_pkg::ST_OUT_SHOW: begin
        if (status.out_free) begin
          if (status.i_last) state_next = wffgc_pkg::ST_IDLE;
          else state_next = wffgc_pkg::ST_OUT_RD;
        end
      end
      default:               state_next = wffgc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.to_weight = 1'b0;
    case (state)
      wffgc_pkg::ST_IDLE:     cmd.op = wffgc_pkg::OP_LOAD;
      wffgc_pkg::ST_RS_RD:    cmd.op = wffgc_pkg::OP_RS_RD;
      wffgc_pkg::ST_RS_ACC:   cmd.op = wffgc_pkg::OP_RS_ACC;
      wffgc_pkg::ST_EU_VRD:   cmd.op = wffgc_pkg::OP_EU_VRD;
      wffgc_pkg::ST_EU_VCAP:  cmd.op = wffgc_pkg::OP_EU_VCAP;
      wffgc_pkg::ST_EU_RD:    cmd.op = wffgc_pkg::OP_EU_RD;
      wffgc_pkg::ST_EU_WR:    cmd.op = wffgc_pkg::OP_EU_WR;
      wffgc_pkg::ST_RW_RD: begin
        cmd.op        = wffgc_pkg::OP_RS_RD;
        cmd.to_weight = 1'b1;
      end
      wffgc_pkg::ST_RW_ACC: begin
        cmd.op        = wffgc_pkg::OP_RS_ACC;
        cmd.to_weight = 1'b1;
      end
      wffgc_pkg::ST_PK_RD:    cmd.op = wffgc_pkg::OP_PK_RD;
      wffgc_pkg::ST_PK_CMP:   cmd.op = wffgc_pkg::OP_PK_CMP;
      wffgc_pkg::ST_CO_RD:    cmd.op = wffgc_pkg::OP_CO_RD;
      wffgc_pkg::ST_CO_ACC:   cmd.op = wffgc_pkg::OP_CO_ACC;
      wffgc_pkg::ST_CO_SET:   cmd.op = wffgc_pkg::OP_CO_SET;
      wffgc_pkg::ST_DB_RD:    cmd.op = wffgc_pkg::OP_DB_RD;
      wffgc_pkg::ST_DB_WR:    cmd.op = wffgc_pkg::OP_DB_WR;
      wffgc_pkg::ST_OUT_RD:   cmd.op = wffgc_pkg::OP_OUT_RD;
      wffgc_pkg::ST_OUT_SHOW: cmd.op = wffgc_pkg::OP_OUT_SHOW;
      default:                cmd.op = wffgc_pkg::OP_LOAD;
    endcase
  end
endmodule

// ----- rtl/wffgc_dp.sv -----
// datapath: edge, value, weight and color memories, counters, output register
// uses wffgc_pkg, wffgc_in_if and wffgc_out_if
`timescale 1ns / 1ps
module wffgc_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [wffgc_pkg::CNT_BITS-1:0]  node_count,
  input  logic [wffgc_pkg::PASS_BITS-1:0] weight_passes,
  input  wffgc_pkg::cmd_t                 cmd,
  output wffgc_pkg::status_t              status,
  wffgc_in_if.sink                        matrix,
  wffgc_out_if.source                     result
);
  localparam int NB = wffgc_pkg::NODE_BITS;
  localparam int AB = wffgc_pkg::ADDR_BITS;
  localparam int CB = wffgc_pkg::COLOR_BITS;

  wffgc_pkg::weight_t edge_mem   [wffgc_pkg::CELLS];
  wffgc_pkg::weight_t value_mem  [wffgc_pkg::MAX_NODES];
  wffgc_pkg::weight_t weight_mem [wffgc_pkg::MAX_NODES];
  logic [CB-1:0]      color_mem  [wffgc_pkg::MAX_NODES];

  wffgc_pkg::weight_t edge_q, value_q, weight_q, acc, vi, best_w, acc_sum, w_dbl;
  logic [CB-1:0]      color_q, top, first_free;
  logic [wffgc_pkg::CNT_BITS-1:0]  n_act, n_m1;
  logic [wffgc_pkg::POS_BITS-1:0]  pos, nn;
  logic [wffgc_pkg::PASS_BITS-1:0] pass, passes;
  logic [NB-1:0] i, j, k, best;
  logic [AB-1:0] base, cur_base, row_addr, cur_addr;
  logic [wffgc_pkg::MAX_NODES-1:0] colored, used;
  logic fire, found, edge_nz, free, i_last, j_last;
  wffgc_pkg::op_t op;

  assign op = cmd.op;

  always_comb begin
    if (node_count == '0) n_act = wffgc_pkg::CNT_BITS'(1);
    else if (node_count > wffgc_pkg::CNT_BITS'(wffgc_pkg::MAX_NODES))
      n_act = wffgc_pkg::CNT_BITS'(wffgc_pkg::MAX_NODES);
    else n_act = node_count;
  end

  assign n_m1     = n_act - wffgc_pkg::CNT_BITS'(1);
  assign nn       = wffgc_pkg::POS_BITS'(n_act) * wffgc_pkg::POS_BITS'(n_act);
  assign passes   = (weight_passes == '0) ? wffgc_pkg::PASS_BITS'(1) : weight_passes;
  assign cur_base = AB'(best) * AB'(n_act);
  assign row_addr = base + AB'(j);
  assign cur_addr = cur_base + AB'(j);
  assign i_last   = (i == n_m1[NB-1:0]);
  assign j_last   = (j == n_m1[NB-1:0]);
  assign edge_nz  = (edge_q != '0);
  assign acc_sum  = wffgc_pkg::sat_add(acc, edge_q);
  assign w_dbl    = wffgc_pkg::sat_add(weight_q, weight_q);
  assign free     = !result.valid || result.ready;

  assign matrix.ready = (op == wffgc_pkg::OP_LOAD);
  assign fire         = matrix.valid && matrix.ready;

  always_comb begin
    first_free = '0;
    for (int b = wffgc_pkg::MAX_NODES - 1; b >= 0; b--) begin
      if (!used[b]) first_free = CB'(b);
    end
  end

  assign status.go        = fire && matrix.matrix_last;
  assign status.j_last    = j_last;
  assign status.i_last    = i_last;
  assign status.pass_last = (pass == passes - wffgc_pkg::PASS_BITS'(1));
  assign status.k_last    = (k == n_m1[NB-1:0]);
  assign status.out_free  = free;

  // edge memory
  always_ff @(posedge clk) begin
    if (fire && pos < nn) begin
      edge_mem[pos[AB-1:0]] <= wffgc_pkg::WEIGHT_BITS'(matrix.edge_weight);
    end else if (op == wffgc_pkg::OP_EU_WR && edge_nz) begin
      edge_mem[row_addr] <= wffgc_pkg::sat_add(vi, value_q);
    end
    if (op == wffgc_pkg::OP_CO_RD || op == wffgc_pkg::OP_DB_RD) begin
      edge_q <= edge_mem[cur_addr];
    end else begin
      edge_q <= edge_mem[row_addr];
    end
  end

  // node value memory
  always_ff @(posedge clk) begin
    if (op == wffgc_pkg::OP_RS_ACC && !cmd.to_weight && j_last) begin
      value_mem[i] <= acc_sum;
    end
    if (op == wffgc_pkg::OP_EU_VRD) value_q <= value_mem[i];
    else value_q <= value_mem[j];
  end

  // node weight memory
  always_ff @(posedge clk) begin
    if (op == wffgc_pkg::OP_RS_ACC && cmd.to_weight && j_last) begin
      weight_mem[i] <= acc_sum;
    end else if (op == wffgc_pkg::OP_DB_WR && edge_nz) begin
      weight_mem[j] <= w_dbl;
    end
    if (op == wffgc_pkg::OP_PK_RD) weight_q <= weight_mem[i];
    else weight_q <= weight_mem[j];
  end

  // color memory
  always_ff @(posedge clk) begin
    if (op == wffgc_pkg::OP_CO_SET) color_mem[best] <= first_free;
    if (op == wffgc_pkg::OP_OUT_RD || op == wffgc_pkg::OP_OUT_SHOW) color_q <= color_mem[i];
    else color_q <= color_mem[j];
  end

  // counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      colored <= '0;
      found   <= 1'b0;
      i       <= '0;
      j       <= '0;
      k       <= '0;
      base    <= '0;
      pass    <= '0;
    end else begin
      case (op)
        wffgc_pkg::OP_LOAD: begin
          if (fire) begin
            if (matrix.matrix_last) begin
              pos     <= '0;
              colored <= '0;
              found   <= 1'b0;
              i       <= '0;
              j       <= '0;
              k       <= '0;
              base    <= '0;
              pass    <= '0;
            end else if (pos < nn) begin
              pos <= pos + wffgc_pkg::POS_BITS'(1);
            end
          end
        end
        wffgc_pkg::OP_RS_ACC, wffgc_pkg::OP_EU_WR: begin
          if (j_last) begin
            j <= '0;
            if (i_last) begin
              i    <= '0;
              base <= '0;
              if (op == wffgc_pkg::OP_RS_ACC && cmd.to_weight) begin
                pass <= pass + wffgc_pkg::PASS_BITS'(1);
              end
            end else begin
              i    <= i + NB'(1);
              base <= base + AB'(n_act);
            end
          end else begin
            j <= j + NB'(1);
          end
        end
        wffgc_pkg::OP_PK_CMP: begin
          if (!colored[i] && (!found || weight_q > best_w)) begin
            found <= 1'b1;
          end
          i <= i_last ? '0 : i + NB'(1);
        end
        wffgc_pkg::OP_CO_ACC: j <= j_last ? '0 : j + NB'(1);
        wffgc_pkg::OP_CO_SET: begin
          colored[best] <= 1'b1;
          found         <= 1'b0;
        end
        wffgc_pkg::OP_DB_WR: begin
          if (j_last) begin
            j <= '0;
            k <= k + NB'(1);
          end else begin
            j <= j + NB'(1);
          end
        end
        wffgc_pkg::OP_OUT_SHOW: begin
          if (free) i <= i_last ? '0 : i + NB'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    case (op)
      wffgc_pkg::OP_LOAD: begin
        acc  <= '0;
        used <= '0;
        top  <= '0;
      end
      wffgc_pkg::OP_RS_ACC: acc <= j_last ? '0 : acc_sum;
      wffgc_pkg::OP_EU_VCAP: vi <= value_q;
      wffgc_pkg::OP_PK_CMP: begin
        if (!colored[i] && (!found || weight_q > best_w)) begin
          best   <= i;
          best_w <= weight_q;
        end
      end
      wffgc_pkg::OP_CO_ACC: begin
        if (edge_nz && colored[j]) used[color_q] <= 1'b1;
      end
      wffgc_pkg::OP_CO_SET: begin
        used <= '0;
        if (first_free > top) top <= first_free;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (op == wffgc_pkg::OP_OUT_SHOW && free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == wffgc_pkg::OP_OUT_SHOW && free) begin
      result.node_index  <= i;
      result.node_color  <= color_q;
      result.colors_used <= wffgc_pkg::USED_BITS'(top) + wffgc_pkg::USED_BITS'(1);
      result.result_last <= i_last;
    end
  end
endmodule

// ----- tb/tb.sv -----
// testbench for the weighted first-fit graph coloring unit: streams adjacency matrices,
// predicts every node color and the color count, and checks each result beat in order
// depends on wffgc_pkg, wffgc_in_if, wffgc_out_if and the unit itself
`timescale 1ns / 1ps
module tb;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [wffgc_pkg::EDGE_BITS-1:0] weight;
    logic                            last;
  } entry_t;

  typedef struct {
    logic [wffgc_pkg::NODE_BITS-1:0]  index;
    logic [wffgc_pkg::COLOR_BITS-1:0] color;
    logic [wffgc_pkg::USED_BITS-1:0]  used;
    logic                             last;
  } report_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [wffgc_pkg::CFG_ADDR_BITS-1:0] paddr;
  logic [wffgc_pkg::CFG_DATA_BITS-1:0] pwdata, prdata;

  wffgc_in_if  m_if();
  wffgc_out_if r_if();

  weighted_first_fit_graph_coloring_unit dut (
    .clk(clk), .rst(rst), .matrix(m_if), .result(r_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  wffgc_pkg::weight_t               edge_mem [wffgc_pkg::CELLS];
  wffgc_pkg::weight_t               node_val [wffgc_pkg::MAX_NODES];
  wffgc_pkg::weight_t               node_wt  [wffgc_pkg::MAX_NODES];
  logic [wffgc_pkg::COLOR_BITS-1:0] node_col [wffgc_pkg::MAX_NODES];
  logic                             painted  [wffgc_pkg::MAX_NODES];
  int                               load_pos;
  logic [5:0]                       cfg_nodes;
  logic [3:0]                       cfg_passes;

  entry_t  feed_q[$];
  report_t color_q[$];

  int  mismatches;
  int  beats_checked;
  int  matrices_sent;
  int  entries_sent;
  int  entries_accepted;
  int  cycles;
  bit  quiet;
  int  gap_left;
  int  stall_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic wffgc_pkg::weight_t clip_sum(wffgc_pkg::weight_t a,
                                                  wffgc_pkg::weight_t b);
    logic [wffgc_pkg::WEIGHT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[wffgc_pkg::WEIGHT_BITS] ? {wffgc_pkg::WEIGHT_BITS{1'b1}}
                                     : s[wffgc_pkg::WEIGHT_BITS-1:0];
  endfunction

  function automatic int live_nodes();
    if (cfg_nodes == 0) return 1;
    if (cfg_nodes > wffgc_pkg::MAX_NODES) return wffgc_pkg::MAX_NODES;
    return int'(cfg_nodes);
  endfunction

  function automatic void sum_rows(int n, bit to_weight);
    wffgc_pkg::weight_t acc;
    for (int i = 0; i < n; i++) begin
      acc = '0;
      for (int j = 0; j < n; j++) acc = clip_sum(acc, edge_mem[i*n+j]);
      if (to_weight) node_wt[i] = acc;
      else node_val[i] = acc;
    end
  endfunction

  function automatic void color_graph(int n);
    int passes;
    int cur;
    int c;
    int top;
    bit found;
    bit taken [wffgc_pkg::MAX_NODES+1];
    report_t r;
    passes = (cfg_passes == 0) ? 1 : int'(cfg_passes);
    for (int p = 0; p < passes; p++) begin
      sum_rows(n, 1'b0);
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          if (edge_mem[i*n+j] != 0) edge_mem[i*n+j] = clip_sum(node_val[i], node_val[j]);
      sum_rows(n, 1'b1);
    end
    for (int i = 0; i < wffgc_pkg::MAX_NODES; i++) painted[i] = 1'b0;
    for (int k = 0; k < n; k++) begin
      cur = 0;
      found = 1'b0;
      for (int i = 0; i < n; i++)
        if (!painted[i] && (!found || node_wt[i] > node_wt[cur])) begin
          cur = i;
          found = 1'b1;
        end
      for (int i = 0; i <= wffgc_pkg::MAX_NODES; i++) taken[i] = 1'b0;
      for (int j = 0; j < n; j++)
        if (edge_mem[cur*n+j] != 0 && painted[j]) taken[node_col[j]] = 1'b1;
      c = 0;
      while (c < wffgc_pkg::MAX_NODES && taken[c]) c++;
      node_col[cur] = c[wffgc_pkg::COLOR_BITS-1:0];
      painted[cur] = 1'b1;
      for (int j = 0; j < n; j++)
        if (edge_mem[cur*n+j] != 0) node_wt[j] = clip_sum(node_wt[j], node_wt[j]);
    end
    top = 0;
    for (int i = 0; i < n; i++) if (node_col[i] > top) top = node_col[i];
    for (int i = 0; i < n; i++) begin
      r.index = i[wffgc_pkg::NODE_BITS-1:0];
      r.color = node_col[i];
      r.used  = wffgc_pkg::USED_BITS'(top + 1);
      r.last  = (i == n - 1);
      color_q.push_back(r);
    end
  endfunction

  function automatic void absorb_entry(logic [wffgc_pkg::EDGE_BITS-1:0] w, logic last);
    int n;
    n = live_nodes();
    if (load_pos < n * n) begin
      edge_mem[load_pos] = wffgc_pkg::weight_t'(w);
      load_pos++;
    end
    if (last) begin
      load_pos = 0;
      color_graph(n);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    entry_t e;
    bit fire;
    if (rst) begin
      m_if.valid       <= 1'b0;
      m_if.edge_weight <= '0;
      m_if.matrix_last <= 1'b0;
      gap_left = 0;
    end else begin
      fire = m_if.valid && m_if.ready;
      if (fire) begin
        absorb_entry(m_if.edge_weight, m_if.matrix_last);
        entries_accepted++;
        gap_left = quiet ? 0 : $urandom_range(0, 4);
      end
      if (!m_if.valid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          m_if.valid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          e = feed_q.pop_front();
          m_if.valid       <= 1'b1;
          m_if.edge_weight <= e.weight;
          m_if.matrix_last <= e.last;
        end else begin
          m_if.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void flag_mismatch(string what, int exp_v, int got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
  endfunction

  // monitor
  always @(posedge clk) begin
    report_t r;
    if (rst) begin
      r_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (r_if.valid && r_if.ready) begin
        if (color_q.size() == 0) begin
          flag_mismatch("unexpected beat, node", 0, int'(r_if.node_index));
        end else begin
          r = color_q.pop_front();
          beats_checked++;
          if (r_if.node_index !== r.index)
            flag_mismatch("node_index", int'(r.index), int'(r_if.node_index));
          if (r_if.node_color !== r.color)
            flag_mismatch("node_color", int'(r.color), int'(r_if.node_color));
          if (r_if.colors_used !== r.used)
            flag_mismatch("colors_used", int'(r.used), int'(r_if.colors_used));
          if (r_if.result_last !== r.last)
            flag_mismatch("result_last", int'(r.last), int'(r_if.result_last));
        end
        stall_left = quiet ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        r_if.ready <= 1'b0;
      end else begin
        r_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb failed");
      $finish;
    end
  end

  task automatic cfg_write(logic reg_sel, logic [wffgc_pkg::CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= wffgc_pkg::CFG_ADDR_BITS'(reg_sel) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (reg_sel == wffgc_pkg::REG_NODE_COUNT) cfg_nodes = value[5:0];
    else cfg_passes = value[3:0];
  endtask

  task automatic drain();
    while (entries_accepted < entries_sent || color_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic setup(int nodes, int passes);
    drain();
    cfg_write(wffgc_pkg::REG_NODE_COUNT, wffgc_pkg::CFG_DATA_BITS'(nodes));
    cfg_write(wffgc_pkg::REG_WEIGHT_PASSES, wffgc_pkg::CFG_DATA_BITS'(passes));
  endtask

  // fill: 0 random by density, 1 all zero, 2 all full scale
  task automatic queue_matrix(int fill, int density, int extra);
    entry_t e;
    int total;
    total = live_nodes() * live_nodes() + extra;
    for (int k = 0; k < total; k++) begin
      case (fill)
        1: e.weight = '0;
        2: e.weight = '1;
        default: begin
          if ($urandom_range(0, 99) < density)
            e.weight = wffgc_pkg::EDGE_BITS'($urandom_range(1, 255));
          else e.weight = '0;
        end
      endcase
      e.last = (k == total - 1);
      feed_q.push_back(e);
    end
    entries_sent += total;
    matrices_sent++;
  endtask

  initial begin
    int n, p;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cfg_nodes = 6'(wffgc_pkg::MAX_NODES);
    cfg_passes = 4'd1;
    load_pos = 0;
    quiet = 1'b0;
    for (int i = 0; i < wffgc_pkg::CELLS; i++) edge_mem[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty, full and mixed small graphs, clamped registers, saturation
    setup(2, 1);
    queue_matrix(1, 0, 0);
    queue_matrix(2, 0, 0);
    queue_matrix(0, 50, 2);
    setup(0, 0);
    queue_matrix(2, 0, 0);
    queue_matrix(1, 0, 3);
    setup(6, 15);
    queue_matrix(2, 0, 0);

    // random small graphs
    while (entries_sent < 150) begin
      n = $urandom_range(2, 6);
      case ($urandom_range(0, 5))
        0: p = 0;
        1: p = $urandom_range(9, 15);
        default: p = $urandom_range(1, 8);
      endcase
      setup(n, p);
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3))
        queue_matrix(0, $urandom_range(10, 100), ($urandom_range(0, 4) == 0) ? 2 : 0);
    end
    quiet = 1'b0;

    // larger graph with several weighting passes
    setup(12, 8);
    queue_matrix(0, 40, 0);
    drain();

    $display("%0d matrices, %0d entries sent, %0d result beats checked",
             matrices_sent, entries_sent, beats_checked);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/wffgc_pkg.sv
rtl/wffgc_in_if.sv
rtl/wffgc_out_if.sv
rtl/wffgc_cfg.sv
rtl/wffgc_ctrl.sv
rtl/wffgc_dp.sv
rtl/weighted_first_fit_graph_coloring_unit.sv
tb/tb.sv
